### rtl/core/bpc_pkg.sv
// Types and constants shared by the button press commissioning block.
package bpc_pkg;

	localparam int unsigned DEB_W   = 10;
	localparam int unsigned PRESS_W = 16;
	localparam int unsigned TOUT_W  = 18;
	localparam int unsigned STEADY_W = 11;
	localparam int unsigned PCNT_W  = 17;
	localparam int unsigned TIMER_W = 18;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE      = 3'd0,
		CFG_LONG_PRESS    = 3'd1,
		CFG_FACTORY_RESET = 3'd2,
		CFG_READY_TIMEOUT = 3'd3,
		CFG_FAILED_HOLD   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_READY  = 2'd1,
		MODE_FAILED = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_ACTIVE  = 2'd1,
		EV_FAILED  = 2'd2,
		EV_FACTORY = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_SHORT   = 2'd1,
		KIND_LONG    = 2'd2,
		KIND_FACTORY = 2'd3
	} kind_t;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST      = 10'd50;
	localparam logic [PRESS_W-1:0] LONG_PRESS_RST    = 16'd3000;
	localparam logic [PRESS_W-1:0] FACTORY_RESET_RST = 16'd10000;
	localparam logic [TOUT_W-1:0]  READY_TIMEOUT_RST = 18'd180000;
	localparam logic [PRESS_W-1:0] FAILED_HOLD_RST   = 16'd5000;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce_ms;
		logic [PRESS_W-1:0] long_press_ms;
		logic [PRESS_W-1:0] factory_reset_ms;
		logic [TOUT_W-1:0]  ready_timeout_ms;
		logic [PRESS_W-1:0] failed_hold_ms;
	} cfg_t;

	typedef struct packed {
		mode_t  mode;
		event_t event_res;
		kind_t  press_kind;
		logic   held;
	} res_t;

endpackage

### rtl/core/bpc_if.sv
// Valid/ready channel interfaces for tick beats and result beats.
interface bpc_tick_if;
	logic valid;
	logic ready;
	logic button_level;
	logic stop_request;

	modport source (output valid, output button_level, output stop_request, input ready);
	modport sink (input valid, input button_level, input stop_request, output ready);
endinterface

interface bpc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] event_res;
	logic [1:0] press_kind;
	logic       held;

	modport source (output valid, output mode, output event_res, output press_kind,
		output held, input ready);
	modport sink (input valid, input mode, input event_res, input press_kind,
		input held, output ready);
endinterface

### rtl/core/bpc_core.sv
// Debounce, press timing and mode machine; state advances once per accepted tick.
module bpc_core import bpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic button_level,
	input  logic stop_request,
	input  cfg_t cfg,
	output res_t res
);

	logic                last_raw_q;
	logic [STEADY_W-1:0] steady_q;
	logic                stable_q;
	logic [PCNT_W-1:0]   press_q;
	mode_t               mode_q;
	logic [TIMER_W-1:0]  timer_q;

	logic [STEADY_W-1:0] steady_d;
	logic                stable_d;
	logic [PCNT_W-1:0]   press_d;
	mode_t               mode_d;
	logic [TIMER_W-1:0]  timer_d;
	event_t              event_d;
	kind_t               kind_d;
	logic                change;

	always_comb begin
		steady_d = (button_level != last_raw_q) ? '0 :
			((steady_q == '1) ? steady_q : steady_q + 1'b1);
		change = (steady_d > {1'b0, cfg.debounce_ms}) && (button_level != stable_q);
	end

	// next state
	always_comb begin
		timer_d  = timer_q;
		press_d  = press_q;
		mode_d   = mode_q;
		stable_d = stable_q;
		event_d  = EV_NONE;
		kind_d   = KIND_NONE;
		if ((mode_q == MODE_READY || mode_q == MODE_FAILED) && timer_q != '1) begin
			timer_d = timer_q + 1'b1;
		end
		if (!stable_q && press_q != '1) begin
			press_d = press_q + 1'b1;
		end
		if (change) begin
			stable_d = button_level;
			if (!button_level) begin
				press_d = '0;
			end else if (press_d >= {1'b0, cfg.factory_reset_ms}) begin
				kind_d  = KIND_FACTORY;
				event_d = EV_FACTORY;
				mode_d  = MODE_IDLE;
				timer_d = '0;
			end else if (press_d >= {1'b0, cfg.long_press_ms}) begin
				kind_d = KIND_LONG;
				if (mode_q == MODE_IDLE) begin
					mode_d  = MODE_READY;
					timer_d = '0;
					event_d = EV_ACTIVE;
				end
			end else begin
				kind_d = KIND_SHORT;
			end
		end
		if (mode_d == MODE_READY && timer_d > cfg.ready_timeout_ms) begin
			mode_d  = MODE_FAILED;
			timer_d = '0;
			event_d = EV_FAILED;
		end
		if (mode_d == MODE_FAILED && timer_d > {{(TIMER_W-PRESS_W){1'b0}}, cfg.failed_hold_ms})
		begin
			mode_d  = MODE_IDLE;
			timer_d = '0;
		end
		if (stop_request) begin
			mode_d  = MODE_IDLE;
			timer_d = '0;
		end
	end

	// outputs
	always_comb begin
		res.mode       = mode_d;
		res.event_res  = event_d;
		res.press_kind = kind_d;
		res.held       = ~stable_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b1;
			steady_q   <= '0;
			stable_q   <= 1'b1;
			press_q    <= '0;
			mode_q     <= MODE_IDLE;
			timer_q    <= '0;
		end else if (advance) begin
			last_raw_q <= button_level;
			steady_q   <= steady_d;
			stable_q   <= stable_d;
			press_q    <= press_d;
			mode_q     <= mode_d;
			timer_q    <= timer_d;
		end
	end

	a_ready_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> timer_q == '0)
		else $error("timer running in idle");

	a_factory_forces_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_d == KIND_FACTORY |=> mode_q == MODE_IDLE && timer_q == '0)
		else $error("factory reset did not force idle");

	a_held_tracks_press: assert property (@(posedge clk) disable iff (!arst_n)
		advance && change && !button_level |=> press_q == '0 && !stable_q)
		else $error("press timer not restarted on press");

endmodule

### rtl/core/button_press_commissioning_fsm_top.sv
// Top level of the button press commissioning block.
//
// Channels: tick (sink) takes one beat per millisecond tick with the raw
// active-low button_level and stop_request; res (source) gives one beat per
// tick with mode, event_res, press_kind and held after that tick.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one of five registers
// (debounce, long press, factory reset, ready timeout, failed hold) at a
// rising edge; indexes five to seven are ignored. Write only while idle.
// Output: the result beat is registered and appears in the cycle after its tick beat is taken.
// Throughput: one tick per cycle while res is not held off; the state update and
// classification are a single pass of counters and compares between the state
// registers and the result register.
// Reset: arst_n clears the result channel, returns the button state to
// released, the mode to idle and the registers to their default values.
// Stall: while res is held off, the waiting beat stays in the result
// register and tick is not taken until that beat leaves; a beat can be taken
// in the same cycle as the waiting one goes.
module button_press_commissioning_fsm_top import bpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bpc_tick_if.sink              tick,
	bpc_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	res_t res_d;
	res_t res_q;
	logic res_valid_q;
	logic take;

	assign tick.ready = !res_valid_q || res.ready;
	assign take       = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
			cfg_q.factory_reset_ms <= FACTORY_RESET_RST;
			cfg_q.ready_timeout_ms <= READY_TIMEOUT_RST;
			cfg_q.failed_hold_ms   <= FAILED_HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DEBOUNCE:      cfg_q.debounce_ms      <= cfg_wdata[DEB_W-1:0];
				CFG_LONG_PRESS:    cfg_q.long_press_ms    <= cfg_wdata[PRESS_W-1:0];
				CFG_FACTORY_RESET: cfg_q.factory_reset_ms <= cfg_wdata[PRESS_W-1:0];
				CFG_READY_TIMEOUT: cfg_q.ready_timeout_ms <= cfg_wdata[TOUT_W-1:0];
				CFG_FAILED_HOLD:   cfg_q.failed_hold_ms   <= cfg_wdata[PRESS_W-1:0];
				default: ;
			endcase
		end
	end

	bpc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (take),
		.button_level (tick.button_level),
		.stop_request (tick.stop_request),
		.cfg          (cfg_q),
		.res          (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.mode       = res_q.mode;
	assign res.event_res  = res_q.event_res;
	assign res.press_kind = res_q.press_kind;
	assign res.held       = res_q.held;

	a_beat_follows_tick: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> res_valid_q)
		else $error("no result beat after tick");

	a_factory_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.press_kind == KIND_FACTORY |-> res_q.event_res == EV_FACTORY)
		else $error("factory release without factory event");

	a_active_from_long: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.event_res == EV_ACTIVE |-> res_q.press_kind == KIND_LONG)
		else $error("commissioning entered without long press");

	a_held_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.held |-> res_q.press_kind == KIND_NONE)
		else $error("release classified while held");

endmodule
